/* rtl/core/gtd_pkg.sv */
`default_nettype none

package gtd_pkg;

    // Default sizes handed to the top level parameters.
    localparam int SAMPLE_W_DEF = 16;
    localparam int MAX_BLOCK_DEF = 4096;

    // Fixed field widths.
    localparam int ST_W       = 48;  // state words, real and imaginary parts
    localparam int COEF_W     = 18;  // coefficient registers
    localparam int SPB_W      = 13;  // block length register
    localparam int POWER_W    = 64;
    localparam int FRAC_W     = 16;  // fraction bits of the coefficients
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Shared multiplier: signed operands and the kept product width.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 65;
    // Partial product of the low half, shifted down by the fraction bits.
    localparam int LO_W   = 19;
    // Working width of the sums before saturation.
    localparam int SUM_W  = 52;
    localparam int HALF_W = ST_W - FRAC_W;  // upper part of a state word

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COSINE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [COEF_W-1:0] FEEDBACK_RST = 18'd0;
    localparam logic [COEF_W-1:0] COSINE_RST   = 18'd0;
    localparam logic [COEF_W-1:0] SINE_RST     = 18'd65536;
    localparam logic [SPB_W-1:0]  BLOCK_RST    = 13'd256;

    // Multiplier operand selection.
    localparam int MS_W = 3;
    localparam logic [MS_W-1:0] MS_D1_LO_FB  = 3'd0;
    localparam logic [MS_W-1:0] MS_D1_HI_FB  = 3'd1;
    localparam logic [MS_W-1:0] MS_D2_LO_COS = 3'd2;
    localparam logic [MS_W-1:0] MS_D2_HI_COS = 3'd3;
    localparam logic [MS_W-1:0] MS_D2_LO_SIN = 3'd4;
    localparam logic [MS_W-1:0] MS_D2_HI_SIN = 3'd5;
    localparam logic [MS_W-1:0] MS_SQ_RE     = 3'd6;
    localparam logic [MS_W-1:0] MS_SQ_IM     = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [MS_W-1:0] mul_sel;
        logic            in_accept;
        logic            load_lo;
        logic            update;
        logic            load_re;
        logic            load_im;
        logic            load_acc;
        logic            emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic complete;
        logic out_busy;
    } t_stat;

    // Clamp a working sum to the signed 48-bit range.
    function automatic logic [ST_W-1:0] sat48(input logic [SUM_W-1:0] x);
        logic [ST_W-1:0] res;
        if ((&x[SUM_W-1:ST_W-1]) || !(|x[SUM_W-1:ST_W-1])) begin
            res = x[ST_W-1:0];
        end else if (x[SUM_W-1]) begin
            res = {1'b1, {(ST_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ST_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gtd_in_if.sv */
`default_nettype none

interface gtd_in_if #(
    parameter int SAMPLE_WIDTH = gtd_pkg::SAMPLE_W_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* rtl/core/gtd_out_if.sv */
`default_nettype none

interface gtd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [gtd_pkg::ST_W-1:0]   real_part;
    logic signed [gtd_pkg::ST_W-1:0]   imag_part;
    logic        [gtd_pkg::POWER_W-1:0] power_out;

    modport source (output valid, output real_part, output imag_part, output power_out,
                    input ready);
    modport sink   (input valid, input real_part, input imag_part, input power_out,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/gtd_cfg_if.sv */
`default_nettype none

interface gtd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gtd_pkg::CFG_IDX_W-1:0]      index;
    logic [gtd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/gtd_ctrl.sv */
`default_nettype none

module gtd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output gtd_pkg::t_cmd       o_cmd,
    input  wire gtd_pkg::t_stat i_stat
);
    import gtd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HI   = 4'd1;
    localparam logic [3:0] S_UPD  = 4'd2;
    localparam logic [3:0] S_C0   = 4'd3;
    localparam logic [3:0] S_C1   = 4'd4;
    localparam logic [3:0] S_C2   = 4'd5;
    localparam logic [3:0] S_S1   = 4'd6;
    localparam logic [3:0] S_S2   = 4'd7;
    localparam logic [3:0] S_Q1   = 4'd8;
    localparam logic [3:0] S_Q2   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.mul_sel   = MS_D1_LO_FB;
                o_cmd.in_accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                o_cmd.mul_sel = MS_D1_HI_FB;
                o_cmd.load_lo = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.mul_sel = MS_D1_LO_FB;
                o_cmd.update  = 1'b1;
                n_state       = i_stat.complete ? S_C0 : S_IDLE;
            end
            S_C0: begin
                o_cmd.mul_sel = MS_D2_LO_COS;
                n_state       = S_C1;
            end
            S_C1: begin
                o_cmd.mul_sel = MS_D2_HI_COS;
                o_cmd.load_lo = 1'b1;
                n_state       = S_C2;
            end
            S_C2: begin
                o_cmd.mul_sel = MS_D2_LO_SIN;
                o_cmd.load_re = 1'b1;
                n_state       = S_S1;
            end
            S_S1: begin
                o_cmd.mul_sel = MS_D2_HI_SIN;
                o_cmd.load_lo = 1'b1;
                n_state       = S_S2;
            end
            S_S2: begin
                o_cmd.mul_sel = MS_SQ_RE;
                o_cmd.load_im = 1'b1;
                n_state       = S_Q1;
            end
            S_Q1: begin
                o_cmd.mul_sel  = MS_SQ_IM;
                o_cmd.load_acc = 1'b1;
                n_state        = S_Q2;
            end
            S_Q2: begin
                // The product of the second square is held until the result can leave.
                o_cmd.mul_sel = MS_SQ_IM;
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/gtd_dpath.sv */
`default_nettype none

module gtd_dpath #(
    parameter int SAMPLE_WIDTH = gtd_pkg::SAMPLE_W_DEF,
    parameter int MAX_BLOCK    = gtd_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire gtd_pkg::t_cmd                      i_cmd,
    output gtd_pkg::t_stat                          o_stat,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_sample_in,
    input  wire logic                               i_cfg_we,
    input  wire logic [gtd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gtd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic signed [gtd_pkg::ST_W-1:0]         o_real_part,
    output logic signed [gtd_pkg::ST_W-1:0]         o_imag_part,
    output logic [gtd_pkg::POWER_W-1:0]             o_power_out
);
    import gtd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int BLK_W = (CNT_W > SPB_W) ? CNT_W : SPB_W;

    // Configuration registers.
    logic [COEF_W-1:0] r_feedback;
    logic [COEF_W-1:0] r_cosine;
    logic [COEF_W-1:0] r_sine;
    logic [SPB_W-1:0]  r_block;

    // Recurrence state.
    logic [ST_W-1:0]  r_d1;
    logic [ST_W-1:0]  r_d2;
    logic [CNT_W-1:0] r_count;

    // Working registers.
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [PROD_W-1:0]       r_prod;
    logic [LO_W-1:0]         r_lo;
    logic [ST_W-1:0]         r_re;
    logic [ST_W-1:0]         r_im;
    logic [POWER_W-1:0]      r_acc;
    logic                    r_out_valid;
    logic [ST_W-1:0]         r_out_re;
    logic [ST_W-1:0]         r_out_im;
    logic [POWER_W-1:0]      r_out_pw;

    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [2*MUL_W-1:0]   mul_full;
    logic [SUM_W-1:0]     hi_ext;
    logic [SUM_W-1:0]     lo_ext;
    logic [SUM_W-1:0]     n_sum;
    logic [SUM_W-1:0]     re_sum;
    logic [SUM_W-1:0]     im_sum;
    logic [ST_W-1:0]      n_d1;
    logic [BLK_W-1:0]     blk;
    logic [BLK_W:0]       cnt_inc;

    function automatic logic [MUL_W-1:0] lo_op(input logic [ST_W-1:0] v);
        return {{(MUL_W-FRAC_W){1'b0}}, v[FRAC_W-1:0]};
    endfunction

    function automatic logic [MUL_W-1:0] hi_op(input logic [ST_W-1:0] v);
        return {{(MUL_W-HALF_W){v[ST_W-1]}}, v[ST_W-1:FRAC_W]};
    endfunction

    function automatic logic [MUL_W-1:0] coef_op(input logic [COEF_W-1:0] c);
        return {{(MUL_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    // Upper half of a part, the value that is squared.
    function automatic logic [MUL_W-1:0] sq_op(input logic [ST_W-1:0] v);
        return {{(MUL_W-HALF_W){v[ST_W-1]}}, v[ST_W-1:FRAC_W]};
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = lo_op(r_d1);
        mul_b = coef_op(r_feedback);
        unique case (i_cmd.mul_sel)
            MS_D1_LO_FB: begin
                mul_a = lo_op(r_d1);
                mul_b = coef_op(r_feedback);
            end
            MS_D1_HI_FB: begin
                mul_a = hi_op(r_d1);
                mul_b = coef_op(r_feedback);
            end
            MS_D2_LO_COS: begin
                mul_a = lo_op(r_d2);
                mul_b = coef_op(r_cosine);
            end
            MS_D2_HI_COS: begin
                mul_a = hi_op(r_d2);
                mul_b = coef_op(r_cosine);
            end
            MS_D2_LO_SIN: begin
                mul_a = lo_op(r_d2);
                mul_b = coef_op(r_sine);
            end
            MS_D2_HI_SIN: begin
                mul_a = hi_op(r_d2);
                mul_b = coef_op(r_sine);
            end
            MS_SQ_RE: begin
                mul_a = sq_op(r_re);
                mul_b = sq_op(r_re);
            end
            MS_SQ_IM: begin
                mul_a = sq_op(r_im);
                mul_b = sq_op(r_im);
            end
            default: begin
                mul_a = lo_op(r_d1);
                mul_b = coef_op(r_feedback);
            end
        endcase
    end

    assign mul_full = $signed(mul_a) * $signed(mul_b);

    // The full product is the upper partial product plus the lower one shifted down.
    assign hi_ext = r_prod[SUM_W-1:0];
    assign lo_ext = {{(SUM_W-LO_W){r_lo[LO_W-1]}}, r_lo};

    assign n_sum = {{(SUM_W-SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample}
                 + hi_ext + lo_ext
                 - {{(SUM_W-ST_W){r_d2[ST_W-1]}}, r_d2};
    assign n_d1 = sat48(n_sum);

    assign re_sum = {{(SUM_W-ST_W){r_d1[ST_W-1]}}, r_d1} - hi_ext - lo_ext;
    assign im_sum = hi_ext + lo_ext;

    // Effective block length: zero counts as one, long blocks are capped.
    always_comb begin
        if (r_block == '0) begin
            blk = BLK_W'(1);
        end else if (BLK_W'(r_block) > BLK_W'(MAX_BLOCK)) begin
            blk = BLK_W'(MAX_BLOCK);
        end else begin
            blk = BLK_W'(r_block);
        end
    end

    assign cnt_inc         = (BLK_W + 1)'(r_count) + (BLK_W + 1)'(1);
    assign o_stat.complete = (cnt_inc >= {1'b0, blk});
    assign o_stat.out_busy = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feedback  <= FEEDBACK_RST;
            r_cosine    <= COSINE_RST;
            r_sine      <= SINE_RST;
            r_block     <= BLOCK_RST;
            r_d1        <= '0;
            r_d2        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FEEDBACK: r_feedback <= i_cfg_data[COEF_W-1:0];
                    REG_COSINE:   r_cosine   <= i_cfg_data[COEF_W-1:0];
                    REG_SINE:     r_sine     <= i_cfg_data[COEF_W-1:0];
                    REG_BLOCK:    r_block    <= i_cfg_data[SPB_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.update) begin
                r_d2    <= r_d1;
                r_d1    <= n_d1;
                r_count <= cnt_inc[CNT_W-1:0];
            end else if (i_cmd.emit) begin
                r_d1    <= '0;
                r_d2    <= '0;
                r_count <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[PROD_W-1:0];
        if (i_cmd.in_accept) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.load_lo) begin
            r_lo <= r_prod[FRAC_W+LO_W-1:FRAC_W];
        end
        if (i_cmd.load_re) begin
            r_re <= sat48(re_sum);
        end
        if (i_cmd.load_im) begin
            r_im <= sat48(im_sum);
        end
        if (i_cmd.load_acc) begin
            r_acc <= r_prod[POWER_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_re <= r_re;
            r_out_im <= r_im;
            r_out_pw <= r_acc + r_prod[POWER_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_real_part = r_out_re;
    assign o_imag_part = r_out_im;
    assign o_power_out = r_out_pw;

endmodule

`default_nettype wire

/* rtl/core/goertzel_tone_detector_top.sv */
`default_nettype none

// Channel    Dir  Interface   Payload
// i_sample   in   gtd_in_if   sample_in (SAMPLE_WIDTH bits, signed)
// o_result   out  gtd_out_if  real_part, imag_part (48 bits, signed), power_out (64 bits)
// i_cfg      in   gtd_cfg_if  index (2 bits), data (18 bits); always ready
//
// Each sample item is finished before the next is taken: the feedback product is formed in two halves on one
// shared 33 by 33 bit multiplier, then added, saturated and shifted into the state.
// The sample that closes a block is followed by the cosine and sine products and the
// two squares, all on the same multiplier, before the next sample is taken.
// Reset is synchronous and active low; it clears the state and count and loads the
// register defaults. A result waits in the output register while the next block runs;
// only a second finished result stalls the block until the first has been taken.
module goertzel_tone_detector_top #(
    parameter int SAMPLE_WIDTH = gtd_pkg::SAMPLE_W_DEF,
    parameter int MAX_BLOCK    = gtd_pkg::MAX_BLOCK_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gtd_in_if.sink     i_sample,
    gtd_out_if.source  o_result,
    gtd_cfg_if.sink    i_cfg
);
    import gtd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // Configuration writes are always taken; they land in the datapath registers.
    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = in_ready;

    // The controller sequences the shared multiplier and the state update.
    gtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // The datapath holds the registers, the state words, the multiplier and the result.
    gtd_dpath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_BLOCK    (MAX_BLOCK)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample_in (i_sample.sample_in),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_real_part (o_result.real_part),
        .o_imag_part (o_result.imag_part),
        .o_power_out (o_result.power_out)
    );

    // A result only appears after the controller has loaded one.
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(cmd.emit))
        else $error("result valid rose without a load");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !stat.out_busy)
        else $error("result register overwritten");

    // After an item is taken the block works on it before taking another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("second item taken while busy");

    // The state is only advanced once per accepted item, after both halves of its feedback product.
    a_update_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |-> $past(cmd.in_accept, 2))
        else $error("state update without an item");

endmodule

`default_nettype wire
